// ===== src/smx_pkg.sv =====
// smx_pkg: shared types, opcodes, fault codes and sizes of the stack machine executor
// no dependencies
`default_nettype none
package smx_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int DATA_DEPTH  = 1024;
  localparam int CODE_DEPTH  = 4096;

  localparam int SP_W = 10;
  localparam int IP_W = 12;
  localparam int DA_W = $clog2(DATA_DEPTH);
  localparam int FB_W = 10;

  typedef enum logic [4:0] {
    OP_JMP   = 5'd1,
    OP_JNZ   = 5'd2,
    OP_LT    = 5'd3,
    OP_MUL   = 5'd4,
    OP_FRAME = 5'd5,
    OP_LOAD  = 5'd6,
    OP_STORE = 5'd7,
    OP_LI    = 5'd11,
    OP_ADD   = 5'd12,
    OP_SUB   = 5'd13,
    OP_DIV   = 5'd14,
    OP_AND   = 5'd15,
    OP_OR    = 5'd16,
    OP_NOT   = 5'd17,
    OP_EQ    = 5'd18,
    OP_GT    = 5'd19,
    OP_DUP   = 5'd20,
    OP_DROP  = 5'd21,
    OP_NEG   = 5'd22,
    OP_STOP  = 5'd23,
    OP_ZERO  = 5'd24,
    OP_NE    = 5'd25
  } op_t;

  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_OVER  = 3'd1,
    FLT_UNDER = 3'd2,
    FLT_DIVZ  = 3'd3,
    FLT_DADDR = 3'd4,
    FLT_JADDR = 3'd5,
    FLT_BADOP = 3'd6
  } fault_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_DIV,
    ST_WB,
    ST_POP2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [4:0]         op;
    logic signed [31:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        next_ip;
    logic signed [31:0] top_value;
    logic [9:0]         stack_level;
    logic               halted;
    logic [2:0]         fault;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] imm;
    logic [1:0]  need;
    logic        push;
    logic        bad;
  } dec_t;

endpackage
`default_nettype wire

// ===== src/smx_front.sv =====
// smx_front: accepts instructions, classifies opcodes and queues them for the back end
// depends on smx_pkg
`default_nettype none
module smx_front import smx_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     hold,
  output logic          q_valid,
  output dec_t          q_data,
  input  wire logic     q_pop
);

  dec_t       ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_w;
  dec_t       dec_w;

  always_comb begin
    dec_w.op   = in_data.op;
    dec_w.imm  = in_data.immediate;
    dec_w.need = 2'd0;
    dec_w.push = 1'b0;
    dec_w.bad  = 1'b0;
    case (in_data.op)
      OP_JMP, OP_DROP, OP_LT, OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_AND,
      OP_OR, OP_EQ, OP_GT, OP_NE: dec_w.need = 2'd1;
      OP_JNZ, OP_STORE: dec_w.need = 2'd2;
      OP_FRAME, OP_LOAD, OP_NOT, OP_NEG, OP_STOP: dec_w.need = 2'd0;
      OP_LI, OP_DUP, OP_ZERO: dec_w.push = 1'b1;
      default: dec_w.bad = 1'b1;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2) || hold;
  assign push_w   = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push_w ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push_w) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_w) begin
      ent_r[wp_r] <= dec_w;
    end
  end

endmodule
`default_nettype wire

// ===== src/smx_div.sv =====
// smx_div: signed 32-bit divider, one quotient bit per cycle, truncates toward zero
// depends on smx_pkg
`default_nettype none
module smx_div import smx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic        busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [32:0] sh_w, dif_w;

  assign sh_w  = {rem_r, quo_r[31]};
  assign dif_w = sh_w - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = 32'd0;
      neg_nxt  = dividend[31] ^ divisor[31];
      quo_nxt  = dividend[31] ? (32'd0 - dividend) : dividend;
      den_nxt  = divisor[31] ? (32'd0 - divisor) : divisor;
    end else if (busy_r) begin
      if (!dif_w[32]) begin
        rem_nxt = dif_w[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = sh_w[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;

endmodule
`default_nettype wire

// ===== src/smx_back.sv =====
// smx_back: executes queued instructions against the stack and data memories
// depends on smx_pkg and smx_div
`default_nettype none
module smx_back import smx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire dec_t        q_data,
  output logic             q_pop,
  output logic             hold,
  input  wire logic        cfg_valid,
  input  wire logic [9:0]  cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);

  state_t             state_r, state_nxt;
  logic [DA_W-1:0]    clr_r, clr_nxt;
  dec_t               cur_r, cur_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic [IP_W-1:0]    ip_r, ip_nxt, ip_inc1, ip_inc2;
  logic [31:0]        tos_r, tos_nxt, res_r, res_nxt;
  logic               halt_r, halt_nxt;
  fault_t             fault_r, fault_nxt;
  logic [FB_W-1:0]    fb_r;
  logic               out_valid_r, out_valid_nxt, out_load;
  out_item_t          out_r;

  logic [31:0]        stk [STACK_DEPTH];
  logic               stk_we;
  logic [SP_W-1:0]    stk_wa, stk_ra;
  logic [31:0]        stk_wd, stk_rd_r;

  logic [31:0]        dm [DATA_DEPTH];
  logic               dm_we;
  logic [DA_W-1:0]    dm_a;
  logic [31:0]        dm_wd, dm_rd_r;

  logic               div_start, div_done;
  logic [31:0]        div_q, t_w, s_w;
  logic [IP_W:0]      ip_sum1, ip_sum2;

  smx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (s_w),
    .divisor  (t_w),
    .done     (div_done),
    .quotient (div_q)
  );

  assign t_w = tos_r;
  assign s_w = stk_rd_r;
  assign ip_sum1 = {1'b0, ip_r} + (IP_W+1)'(1);
  assign ip_sum2 = {1'b0, ip_r} + (IP_W+1)'(2);
  assign ip_inc1 = (ip_sum1 >= (IP_W+1)'(CODE_DEPTH)) ?
                   IP_W'(ip_sum1 - (IP_W+1)'(CODE_DEPTH)) : ip_sum1[IP_W-1:0];
  assign ip_inc2 = (ip_sum2 >= (IP_W+1)'(CODE_DEPTH)) ?
                   IP_W'(ip_sum2 - (IP_W+1)'(CODE_DEPTH)) : ip_sum2[IP_W-1:0];

  assign hold     = (state_r == ST_CLEAR);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == DA_W'(DATA_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        state_nxt = ST_OUT;
        if (!halt_r && !cur_r.bad && !(sp_r < SP_W'(cur_r.need)) &&
            !(cur_r.push && sp_r == SP_W'(STACK_DEPTH - 1))) begin
          case (cur_r.op)
            OP_LOAD:  if (t_w < 32'(DATA_DEPTH)) state_nxt = ST_LOAD;
            OP_STORE: if (t_w < 32'(DATA_DEPTH)) state_nxt = ST_POP2;
            OP_JNZ:   if (s_w == 32'd0 || t_w < 32'(CODE_DEPTH)) state_nxt = ST_POP2;
            OP_DIV:   if (t_w != 32'd0) state_nxt = ST_DIV;
            OP_LT, OP_MUL, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_EQ, OP_GT, OP_NE:
              state_nxt = ST_WB;
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_DIV:  if (div_done) state_nxt = ST_WB;
      ST_LOAD, ST_WB, ST_POP2: state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    clr_nxt   = clr_r;
    cur_nxt   = cur_r;
    sp_nxt    = sp_r;
    ip_nxt    = ip_r;
    tos_nxt   = tos_r;
    res_nxt   = res_r;
    halt_nxt  = halt_r;
    fault_nxt = fault_r;
    q_pop     = 1'b0;
    stk_we    = 1'b0;
    stk_wa    = sp_r;
    stk_wd    = tos_r;
    stk_ra    = sp_r - SP_W'(1);
    dm_we     = 1'b0;
    dm_a      = t_w[DA_W-1:0];
    dm_wd     = s_w;
    div_start = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + DA_W'(1);
        dm_we   = 1'b1;
        dm_a    = clr_r;
        dm_wd   = 32'd0;
        stk_we  = (clr_r == '0);
        stk_wa  = '0;
        stk_wd  = 32'd0;
      end
      ST_IDLE: begin
        q_pop   = q_valid;
        cur_nxt = q_data;
      end
      ST_EXEC: begin
        if (halt_r) begin
        end else if (cur_r.bad) begin
          halt_nxt = 1'b1; fault_nxt = FLT_BADOP;
        end else if (sp_r < SP_W'(cur_r.need)) begin
          halt_nxt = 1'b1; fault_nxt = FLT_UNDER;
        end else if (cur_r.push && sp_r == SP_W'(STACK_DEPTH - 1)) begin
          halt_nxt = 1'b1; fault_nxt = FLT_OVER;
        end else begin
          case (cur_r.op)
            OP_JMP: begin
              if (t_w >= 32'(CODE_DEPTH)) begin
                halt_nxt = 1'b1; fault_nxt = FLT_JADDR;
              end else begin
                ip_nxt = t_w[IP_W-1:0]; sp_nxt = sp_r - SP_W'(1); tos_nxt = s_w;
              end
            end
            OP_JNZ: begin
              if (s_w != 32'd0 && t_w >= 32'(CODE_DEPTH)) begin
                halt_nxt = 1'b1; fault_nxt = FLT_JADDR;
              end else begin
                ip_nxt = (s_w != 32'd0) ? t_w[IP_W-1:0] : ip_inc1;
                sp_nxt = sp_r - SP_W'(2);
                stk_ra = sp_r - SP_W'(2);
              end
            end
            OP_STORE: begin
              if (t_w >= 32'(DATA_DEPTH)) begin
                halt_nxt = 1'b1; fault_nxt = FLT_DADDR;
              end else begin
                dm_we  = 1'b1;
                ip_nxt = ip_inc1;
                sp_nxt = sp_r - SP_W'(2);
                stk_ra = sp_r - SP_W'(2);
              end
            end
            OP_LOAD: begin
              if (t_w >= 32'(DATA_DEPTH)) begin
                halt_nxt = 1'b1; fault_nxt = FLT_DADDR;
              end else begin
                ip_nxt = ip_inc1;
              end
            end
            OP_DIV: begin
              if (t_w == 32'd0) begin
                halt_nxt = 1'b1; fault_nxt = FLT_DIVZ;
              end else begin
                div_start = 1'b1;
              end
            end
            OP_LT:  res_nxt = 32'($signed(s_w) < $signed(t_w));
            OP_GT:  res_nxt = 32'($signed(t_w) < $signed(s_w));
            OP_EQ:  res_nxt = 32'(s_w == t_w);
            OP_NE:  res_nxt = 32'(s_w != t_w);
            OP_MUL: res_nxt = s_w * t_w;
            OP_ADD: res_nxt = s_w + t_w;
            OP_SUB: res_nxt = s_w - t_w;
            OP_AND: res_nxt = s_w & t_w;
            OP_OR:  res_nxt = s_w | t_w;
            OP_DROP: begin
              sp_nxt = sp_r - SP_W'(1); tos_nxt = s_w; ip_nxt = ip_inc1;
            end
            OP_FRAME: begin
              tos_nxt = t_w + {{(32-FB_W){1'b0}}, fb_r};
              stk_we = 1'b1; stk_wd = tos_nxt; ip_nxt = ip_inc1;
            end
            OP_NOT: begin
              tos_nxt = ~t_w; stk_we = 1'b1; stk_wd = tos_nxt; ip_nxt = ip_inc1;
            end
            OP_NEG: begin
              tos_nxt = 32'd0 - t_w; stk_we = 1'b1; stk_wd = tos_nxt; ip_nxt = ip_inc1;
            end
            OP_LI, OP_DUP, OP_ZERO: begin
              case (cur_r.op)
                OP_LI:   tos_nxt = cur_r.imm;
                OP_DUP:  tos_nxt = t_w;
                default: tos_nxt = 32'd0;
              endcase
              stk_we = 1'b1;
              stk_wa = sp_r + SP_W'(1);
              stk_wd = tos_nxt;
              sp_nxt = sp_r + SP_W'(1);
              ip_nxt = (cur_r.op == OP_LI) ? ip_inc2 : ip_inc1;
            end
            OP_STOP: halt_nxt = 1'b1;
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        tos_nxt = dm_rd_r; stk_we = 1'b1; stk_wd = dm_rd_r;
      end
      ST_DIV: if (div_done) res_nxt = div_q;
      ST_WB: begin
        stk_we  = 1'b1;
        stk_wa  = sp_r - SP_W'(1);
        stk_wd  = res_r;
        tos_nxt = res_r;
        sp_nxt  = sp_r - SP_W'(1);
        ip_nxt  = ip_inc1;
      end
      ST_POP2: tos_nxt = stk_rd_r;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      sp_r        <= '0;
      ip_r        <= '0;
      tos_r       <= 32'd0;
      halt_r      <= 1'b0;
      fault_r     <= FLT_NONE;
      fb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sp_r        <= sp_nxt;
      ip_r        <= ip_nxt;
      tos_r       <= tos_nxt;
      halt_r      <= halt_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) fb_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_r.next_ip     <= ip_r;
      out_r.top_value   <= tos_r;
      out_r.stack_level <= sp_r;
      out_r.halted      <= halt_r;
      out_r.fault       <= fault_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_wa] <= stk_wd;
    stk_rd_r <= stk[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (dm_we) dm[dm_a] <= dm_wd;
    dm_rd_r <= dm[dm_a];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== src/stack_machine_executor.sv =====
// stack_machine_executor: top level of the 32-bit stack machine executor
// depends on smx_pkg, smx_front and smx_back
// One instruction is taken per transfer on the in_ channel and gives one result transfer
// on the out_ channel with the machine state after it. A front end classifies opcodes
// into a two-entry queue; the back end executes one instruction at a time. Most
// instructions go from ST_EXEC to ST_OUT; binary ops, load, store and jnz also pass
// ST_WB, ST_LOAD or ST_POP2, and div waits in ST_DIV for its bit-serial divider.
// After reset a clearing pass zeroes the data memory; no instruction is taken during
// it, configuration writes are.
`default_nettype none
module stack_machine_executor import smx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [9:0]  cfg_data
);

  logic q_valid, q_pop, hold;
  dec_t q_data;

  assign cfg_ready = 1'b1;

  smx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .hold     (hold),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  smx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .hold      (hold),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for stack_machine_executor
// depends on smx_pkg and the stack_machine_executor rtl; a built-in machine model
// predicts the result of every instruction transfer
`default_nettype none
module tb;
  import smx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [9:0] cfg_data = '0;

  stack_machine_executor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // machine model
  logic [31:0] m_stack [STACK_DEPTH];
  logic [31:0] m_mem [DATA_DEPTH];
  logic [SP_W-1:0] m_sp = '0;
  logic [IP_W-1:0] m_ip = '0;
  logic m_halt = 1'b0;
  logic [2:0] m_fault = FLT_NONE;
  logic [FB_W-1:0] m_fb = '0;

  in_item_t instr_q[$];
  out_item_t state_q[$];
  int issued = 0;
  int sent = 0;
  int fails = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  function automatic void classify(input logic [4:0] op, output int need, output bit push,
                                   output bit bad);
    need = 0; push = 1'b0; bad = 1'b0;
    case (op)
      OP_JMP, OP_DROP, OP_LT, OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_AND, OP_OR, OP_EQ,
      OP_GT, OP_NE: need = 1;
      OP_JNZ, OP_STORE: need = 2;
      OP_FRAME, OP_LOAD, OP_NOT, OP_NEG, OP_STOP: need = 0;
      OP_LI, OP_DUP, OP_ZERO: push = 1'b1;
      default: bad = 1'b1;
    endcase
  endfunction

  function automatic logic [2:0] fault_of(input logic [4:0] op);
    int need;
    bit push, bad;
    logic [31:0] t, s;
    classify(op, need, push, bad);
    if (bad) return FLT_BADOP;
    if (int'(m_sp) < need) return FLT_UNDER;
    if (push && int'(m_sp) + 1 >= STACK_DEPTH) return FLT_OVER;
    t = m_stack[m_sp];
    s = (m_sp > 0) ? m_stack[m_sp - SP_W'(1)] : '0;
    case (op)
      OP_JMP: if (t >= CODE_DEPTH) return FLT_JADDR;
      OP_JNZ: if (s != 0 && t >= CODE_DEPTH) return FLT_JADDR;
      OP_DIV: if (t == 0) return FLT_DIVZ;
      OP_LOAD, OP_STORE: if (t >= DATA_DEPTH) return FLT_DADDR;
      default: ;
    endcase
    return FLT_NONE;
  endfunction

  function automatic logic [31:0] quot(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic void exec_instr(input in_item_t it, output out_item_t r);
    logic [2:0] f;
    logic [31:0] t, s, v;
    logic [SP_W-1:0] sp;
    sp = m_sp;
    if (!m_halt) begin
      f = fault_of(it.op);
      if (f != FLT_NONE) begin
        m_halt = 1'b1;
        m_fault = f;
      end else begin
        t = m_stack[sp];
        s = (sp > 0) ? m_stack[sp - SP_W'(1)] : '0;
        case (it.op)
          OP_JMP: begin m_ip = t[IP_W-1:0]; m_sp = sp - SP_W'(1); end
          OP_JNZ: begin
            if (s != 0) m_ip = t[IP_W-1:0];
            else m_ip = m_ip + IP_W'(1);
            m_sp = sp - SP_W'(2);
          end
          OP_DIV, OP_LT, OP_MUL, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_EQ, OP_GT, OP_NE: begin
            case (it.op)
              OP_DIV: v = quot(s, t);
              OP_LT: v = ($signed(s) < $signed(t)) ? 32'd1 : 32'd0;
              OP_GT: v = ($signed(s) > $signed(t)) ? 32'd1 : 32'd0;
              OP_MUL: v = s * t;
              OP_ADD: v = s + t;
              OP_SUB: v = s - t;
              OP_AND: v = s & t;
              OP_OR: v = s | t;
              OP_EQ: v = (s == t) ? 32'd1 : 32'd0;
              default: v = (s != t) ? 32'd1 : 32'd0;
            endcase
            m_stack[sp - SP_W'(1)] = v;
            m_sp = sp - SP_W'(1);
            m_ip = m_ip + IP_W'(1);
          end
          OP_FRAME: begin m_stack[sp] = t + 32'(m_fb); m_ip = m_ip + IP_W'(1); end
          OP_LOAD: begin m_stack[sp] = m_mem[t[DA_W-1:0]]; m_ip = m_ip + IP_W'(1); end
          OP_STORE: begin
            m_mem[t[DA_W-1:0]] = s;
            m_sp = sp - SP_W'(2);
            m_ip = m_ip + IP_W'(1);
          end
          OP_LI: begin
            m_stack[sp + SP_W'(1)] = it.immediate;
            m_sp = sp + SP_W'(1);
            m_ip = m_ip + IP_W'(2);
          end
          OP_NOT: begin m_stack[sp] = ~t; m_ip = m_ip + IP_W'(1); end
          OP_DUP: begin
            m_stack[sp + SP_W'(1)] = t;
            m_sp = sp + SP_W'(1);
            m_ip = m_ip + IP_W'(1);
          end
          OP_DROP: begin m_sp = sp - SP_W'(1); m_ip = m_ip + IP_W'(1); end
          OP_NEG: begin m_stack[sp] = -t; m_ip = m_ip + IP_W'(1); end
          OP_STOP: m_halt = 1'b1;
          OP_ZERO: begin
            m_stack[sp + SP_W'(1)] = '0;
            m_sp = sp + SP_W'(1);
            m_ip = m_ip + IP_W'(1);
          end
          default: ;
        endcase
      end
    end
    r.next_ip = m_ip;
    r.top_value = m_stack[m_sp];
    r.stack_level = m_sp;
    r.halted = m_halt;
    r.fault = m_fault;
  endfunction

  // queue one instruction; unless a halt is wanted, a faulting or stopping one becomes a safe push or drop
  task automatic issue(input logic [4:0] op, input logic [31:0] imm, input int may_halt);
    in_item_t it;
    out_item_t r;
    it.op = op;
    it.immediate = imm;
    if (may_halt == 0 && (fault_of(op) != FLT_NONE || op == OP_STOP))
      it.op = (int'(m_sp) < STACK_DEPTH - 2) ? OP_ZERO : OP_DROP;
    exec_instr(it, r);
    instr_q.push_back(it);
    state_q.push_back(r);
    issued++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1023);
      1: return $urandom_range(0, 15);
      2: return $urandom;
      default: case ($urandom_range(0, 3))
        0: return 32'h7fffffff;
        1: return 32'h80000000;
        2: return 32'hffffffff;
        default: return 32'h0;
      endcase
    endcase
  endfunction

  task automatic random_program(input int n);
    logic [4:0] op;
    int tries;
    repeat (n) begin
      tries = 0;
      do begin
        op = 5'($urandom_range(1, 25));
        tries++;
      end while ((fault_of(op) != FLT_NONE || op == OP_STOP) && tries < 8);
      issue(op, rand_word(), 0);
    end
  endtask

  task automatic drain();
    while (sent != issued || state_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_frame_base(input logic [9:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_fb = v;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) sent <= sent + 1;
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (instr_q.size() > 0) begin
        in_data <= instr_q.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_item_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (state_q.size() == 0) begin
          $display("%0t unexpected result transfer %p", $time, out_data);
          fails <= fails + 1;
        end else begin
          want = state_q.pop_front();
          if (out_data.next_ip !== want.next_ip || out_data.top_value !== want.top_value ||
              out_data.stack_level !== want.stack_level || out_data.halted !== want.halted ||
              out_data.fault !== want.fault) begin
            $display("%0t mismatch expected %p actual %p", $time, want, out_data);
            fails <= fails + 1;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [9:0] fbs [4];
    logic [4:0] badops [10];
    for (int i = 0; i < STACK_DEPTH; i++) m_stack[SP_W'(i)] = '0;
    for (int i = 0; i < DATA_DEPTH; i++) m_mem[DA_W'(i)] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_frame_base(10'd1023);

    // directed: extremes, every opcode but stop, wraps, jumps, memory ends
    issue(OP_LI, 32'h7fffffff, 0); issue(OP_LI, 32'h1, 0); issue(OP_ADD, 0, 0);
    issue(OP_LI, 32'hffffffff, 0); issue(OP_DIV, 0, 0); issue(OP_DUP, 0, 0);
    issue(OP_NEG, 0, 0); issue(OP_MUL, 0, 0); issue(OP_NOT, 0, 0);
    issue(OP_LI, 32'd5, 0); issue(OP_LT, 0, 0); issue(OP_LI, 32'd1, 0);
    issue(OP_GT, 0, 0); issue(OP_ZERO, 0, 0); issue(OP_EQ, 0, 0);
    issue(OP_LI, 32'd7, 0); issue(OP_NE, 0, 0); issue(OP_LI, 32'h55, 0);
    issue(OP_AND, 0, 0); issue(OP_LI, 32'd2, 0); issue(OP_OR, 0, 0);
    issue(OP_LI, 32'd1, 0); issue(OP_SUB, 0, 0); issue(OP_FRAME, 0, 0);
    issue(OP_LI, 32'd1023, 0); issue(OP_STORE, 0, 0); issue(OP_LI, 32'd1023, 0);
    issue(OP_LOAD, 0, 0); issue(OP_LI, 32'd4095, 0); issue(OP_JNZ, 0, 0);
    issue(OP_LI, 32'd4095, 0); issue(OP_LI, 32'd0, 0); issue(OP_LI, 32'd4095, 0);
    issue(OP_JNZ, 0, 0); issue(OP_LI, 32'd4095, 0); issue(OP_JMP, 0, 0);
    issue(OP_DROP, 0, 0);
    drain();

    fbs[0] = 10'd0; fbs[1] = 10'($urandom); fbs[2] = 10'd1023; fbs[3] = 10'($urandom);
    for (int p = 0; p < 4; p++) begin
      write_frame_base(fbs[p]);
      random_program(200);
      drain();
    end

    // final part: no idling, then one fault or stop, then a halted machine
    calm = 1'b1;
    repeat (10) @(posedge clk);
    random_program(20);
    case ($urandom_range(0, 5))
      0: begin
        badops = '{5'd0, 5'd8, 5'd9, 5'd10, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31};
        issue(badops[4'($urandom_range(0, 9))], $urandom, 1);
      end
      1: begin issue(OP_ZERO, 0, 0); issue(OP_DIV, 0, 1); end
      2: begin issue(OP_LI, 32'hffffffff, 0); issue(OP_LOAD, 0, 1); end
      3: begin issue(OP_LI, 32'd4096, 0); issue(OP_JMP, 0, 1); end
      4: begin
        while (m_sp > 0) issue(OP_DROP, 0, 0);
        issue(OP_DROP, 0, 1);
      end
      default: issue(OP_STOP, 0, 1);
    endcase
    repeat (6) issue(5'($urandom), $urandom, 1);
    drain();
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
